FILE: rtl/sorted_set_insert_unit_macros.svh
// Assertion macros shared by the sorted set insert unit RTL.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef SORTED_SET_INSERT_UNIT_MACROS_SVH
`define SORTED_SET_INSERT_UNIT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define SSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define SSI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/sset_pkg.sv
// Shared types and codes for the sorted set insert unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // capture compare flags against the incoming key
        logic ins_en;   // commit the insert shift this cycle
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/sset_cell.sv
// One storage cell of the sorted list: holds an entry, compares, shifts up.
// Depends on sset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sset_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire sset_pkg::t_cell_ctrl i_ctrl,
    input  wire logic signed [31:0] i_cmp_key,
    input  wire logic signed [31:0] i_ins_key,
    input  wire logic signed [31:0] i_prev_value,
    input  wire logic               i_prev_valid,
    input  wire logic               i_prev_lt,
    output logic signed [31:0]      o_value,
    output logic                    o_valid,
    output logic                    o_lt,
    output logic                    o_boundary,
    output logic                    o_match
);

    logic signed [31:0] r_value;
    logic               r_valid;
    logic               r_lt;
    logic               r_eq;

    // first cell whose entry is not below the key
    assign o_boundary = i_prev_lt & ~r_lt;
    assign o_match    = o_boundary & r_eq;
    assign o_value    = r_value;
    assign o_valid    = r_valid;
    assign o_lt       = r_lt;

    // compare flags, taken when an item is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_lt <= r_valid & (r_value < i_cmp_key);
            r_eq <= r_valid & (r_value == i_cmp_key);
        end
    end

    // insert: boundary cell takes the key, cells above take their neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ins_en) begin
            if (o_boundary) begin
                r_valid <= 1'b1;
            end else if (!r_lt) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en) begin
            if (o_boundary) begin
                r_value <= i_ins_key;
            end else if (!r_lt) begin
                r_value <= i_prev_value;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sorted_set_insert_unit.sv
// Top level of the sorted set insert unit: control, cell row, result register.
// Depends on sset_pkg, sset_cell and sorted_set_insert_unit_macros.svh.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_cmd, i_key
//  out     | o_out_valid| i_out_ready | o_found, o_position, o_inserted,
//          |            |             | o_full_res, o_count
//
// For each item, on the accept edge every cell compares its entry with the key;
// in the update state the boundary cell is encoded to the position and, for an
// insert, the whole row shifts at once; no new item is taken until then.
// The update waits while the result register still holds an untaken result.
// Synchronous active-low reset empties the list; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_insert_unit_macros.svh"

module sorted_set_insert_unit #(
    parameter int CAPACITY = 256
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_cmd,
    input  wire logic signed [31:0]                  i_key,
    output logic                                     o_out_valid,
    input  wire                                      i_out_ready,
    output logic                                     o_found,
    output logic [$clog2(CAPACITY + 1) - 1:0]        o_position,
    output logic                                     o_inserted,
    output logic                                     o_full_res,
    output logic [$clog2(CAPACITY + 1) - 1:0]        o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                   r_state;
    logic                   n_state;
    logic                   r_cmd;
    logic signed [31:0]     r_key;
    logic [CW - 1:0]        r_count;
    logic [CW - 1:0]        n_count;

    logic                   r_out_valid;
    logic                   r_found;
    logic [CW - 1:0]        r_position;
    logic                   r_inserted;
    logic                   r_full_res;

    sset_pkg::t_cell_ctrl   ctrl;
    logic                   accept;
    logic                   upd_go;
    logic                   do_ins;
    logic                   found;
    logic                   any_bnd;
    logic [CW - 1:0]        bnd_idx;
    logic [CW - 1:0]        position;
    logic                   full;

    logic signed [31:0]     cell_value [CAPACITY];
    logic                   cell_valid [CAPACITY];
    logic                   cell_lt    [CAPACITY];
    logic [CAPACITY - 1:0]  cell_bnd;
    logic [CAPACITY - 1:0]  cell_match;

    // handshakes
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign upd_go     = (r_state == ST_UPD) & (~r_out_valid | i_out_ready);

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            sset_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_cmp_key    (i_key),
                .i_ins_key    (r_key),
                .i_prev_value (32'sd0),
                .i_prev_valid (1'b0),
                .i_prev_lt    (1'b1),
                .o_value      (cell_value[g]),
                .o_valid      (cell_valid[g]),
                .o_lt         (cell_lt[g]),
                .o_boundary   (cell_bnd[g]),
                .o_match      (cell_match[g])
            );
        end else begin : g_rest
            sset_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_cmp_key    (i_key),
                .i_ins_key    (r_key),
                .i_prev_value (cell_value[g - 1]),
                .i_prev_valid (cell_valid[g - 1]),
                .i_prev_lt    (cell_lt[g - 1]),
                .o_value      (cell_value[g]),
                .o_valid      (cell_valid[g]),
                .o_lt         (cell_lt[g]),
                .o_boundary   (cell_bnd[g]),
                .o_match      (cell_match[g])
            );
        end
    end

    // one-hot boundary to index; no boundary means every entry is below the key
    always_comb begin
        bnd_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_bnd[i]) begin
                bnd_idx = bnd_idx | CW'(i);
            end
        end
    end

    assign any_bnd  = |cell_bnd;
    assign found    = |cell_match;
    assign position = any_bnd ? bnd_idx : r_count;
    assign full     = (r_count == CW'(CAPACITY));
    assign do_ins   = (r_cmd == sset_pkg::CMD_INSERT) & ~found & ~full;

    assign ctrl.cmp_en = accept;
    assign ctrl.ins_en = upd_go & do_ins;

    // sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_UPD;
            ST_UPD:  if (upd_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_count = do_ins ? r_count + CW'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (upd_go) begin
                r_count <= n_count;
            end
        end
    end

    // item held for the update cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_found    <= found;
            r_position <= position;
            r_inserted <= do_ins;
            r_full_res <= (r_cmd == sset_pkg::CMD_INSERT) & ~found & full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_inserted  = r_inserted;
    assign o_full_res  = r_full_res;
    assign o_count     = r_count;

    // checks
    `SSI_NEVER(a_found_and_ins, r_out_valid && r_found && r_inserted, "hit reported as insert")
    `SSI_NEVER(a_ins_and_full, r_out_valid && r_inserted && r_full_res, "insert and refusal")
    `SSI_NEVER(a_count_range, r_count > CW'(CAPACITY), "count above capacity")
    `SSI_ASSERT(a_ins_count, ctrl.ins_en |=> (r_count == $past(r_count) + CW'(1)), "count not bumped")
    `SSI_NEVER(a_pos_range, upd_go && (position > r_count), "position above count")

endmodule

`default_nettype wire

FILE: tb/tb_sorted_set_insert_unit.sv
// Self-checking testbench for sorted_set_insert_unit: a directed table, then random
// insert and lookup items under varied idling, checked against an in-bench sorted set.
// Depends on sset_pkg and the sorted_set_insert_unit RTL.
`timescale 1ns / 1ps

module tb_sorted_set_insert_unit;

    localparam int CAPACITY       = 256;
    localparam int POS_W          = $clog2(CAPACITY + 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int DIRECTED_N     = 20;
    localparam int RANDOM_PER_PHASE = 350;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    // one result item
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             inserted;
        logic             full_res;
        logic [POS_W-1:0] count;
    } t_set_result;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic             cmd;
        logic [31:0]      key;
        logic             typed;
        logic             found;
        logic [POS_W-1:0] position;
        logic             inserted;
        logic             full_res;
        logic [POS_W-1:0] count;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_cmd;
    logic signed [31:0]      i_key;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_found;
    logic [POS_W-1:0]        o_position;
    logic                    o_inserted;
    logic                    o_full_res;
    logic [POS_W-1:0]        o_count;

    // shadow of the block's list
    logic signed [31:0]      set_keys [CAPACITY];
    int                      set_len;

    t_set_result             pending_results [$];
    int                      n_errors;
    int                      idle_cycles;
    int                      in_idle_pct;
    int                      out_stall_pct;

    t_stim_row directed_rows [DIRECTED_N] = '{
        // empty list, then the extremes: expectations read straight off
        '{sset_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 1'b0, 9'd0, 1'b1, 1'b0, 9'd1},
        '{sset_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 1'b1, 9'd0, 1'b0, 1'b0, 9'd1},
        '{sset_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 9'd1, 1'b1, 1'b0, 9'd2},
        '{sset_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, 1'b0, 9'd0, 1'b1, 1'b0, 9'd3},
        '{sset_pkg::CMD_LOOKUP, 32'h8000_0000, 1'b1, 1'b1, 9'd0, 1'b0, 1'b0, 9'd3},
        '{sset_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1, 1'b1, 9'd2, 1'b0, 1'b0, 9'd3},
        '{sset_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b1, 9'd2, 1'b0, 1'b0, 9'd3},
        // the rest are checked against the shadow set
        '{sset_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'h0000_0001, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'h8000_0001, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'h7FFF_FFFE, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_LOOKUP, 32'h5555_5555, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'h5555_5555, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_LOOKUP, 32'h7FFF_FFFE, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_INSERT, 32'h8000_0000, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0},
        '{sset_pkg::CMD_LOOKUP, 32'h0000_0002, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 9'd0}
    };

    sorted_set_insert_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_found    (o_found),
        .o_position (o_position),
        .o_inserted (o_inserted),
        .o_full_res (o_full_res),
        .o_count    (o_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    // Apply one item to the shadow set and return the result it should give.
    // Position is the lower bound: count of entries below the key.
    function automatic t_set_result predict_set_op(input logic cmd,
                                                   input logic signed [31:0] key);
        t_set_result res;
        int          pos;
        bit          hit;
        pos = 0;
        while (pos < set_len && set_keys[pos] < key)
            pos++;
        hit = (pos < set_len) && (set_keys[pos] == key);
        res.found    = hit;
        res.position = pos[POS_W-1:0];
        res.inserted = 1'b0;
        res.full_res = 1'b0;
        if (cmd == sset_pkg::CMD_INSERT && !hit) begin
            if (set_len >= CAPACITY) begin
                res.full_res = 1'b1;
            end else begin
                for (int i = set_len; i > pos; i--)
                    set_keys[i] = set_keys[i - 1];
                set_keys[pos] = key;
                set_len++;
                res.inserted = 1'b1;
            end
        end
        res.count = set_len[POS_W-1:0];
        return res;
    endfunction

    // Present one item, starting in a falling-edge step; returns in the falling-edge
    // step after acceptance without touching valid, so back-to-back items keep it high.
    task automatic drive_item(input logic cmd, input logic signed [31:0] key,
                              input bit use_typed, input t_set_result typed_exp);
        t_set_result predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_key      <= key;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predicted = predict_set_op(cmd, key);
        pending_results.push_back(use_typed ? typed_exp : predicted);
        @(negedge i_clk);
    endtask

    // Random items: mostly keys already held or next to one, so that hits,
    // duplicate inserts and mid-list shifts are common; the list fills on the way.
    task automatic run_random_phase(input int n_items, input int in_pct, input int out_pct);
        logic               cmd;
        logic signed [31:0] key;
        int                 pick;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        for (int n = 0; n < n_items; n++) begin
            cmd  = ($urandom_range(99) < 60) ? sset_pkg::CMD_INSERT : sset_pkg::CMD_LOOKUP;
            pick = $urandom_range(99);
            if (set_len > 0 && pick < 40) begin
                key = set_keys[$urandom_range(set_len - 1)];
            end else if (set_len > 0 && pick < 60) begin
                key = set_keys[$urandom_range(set_len - 1)];
                key = $urandom_range(1) ? key + 32'sd1 : key - 32'sd1;
            end else if (pick < 70) begin
                case ($urandom_range(5))
                    0: key = KEY_MIN;
                    1: key = KEY_MIN + 32'sd1;
                    2: key = KEY_MAX;
                    3: key = KEY_MAX - 32'sd1;
                    4: key = 32'sd0;
                    default: key = -32'sd1;
                endcase
            end else begin
                key = $urandom;
            end
            drive_item(cmd, key, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     expected, actual);
        end
    endtask

    // receiver side: ready changes on the falling edge
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);

    // result checker
    always @(posedge i_clk) begin
        t_set_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: result item with none expected (found %0b position %0d count %0d)",
                         $time, o_found, o_position, o_count);
            end else begin
                exp_res = pending_results.pop_front();
                check_field("found",    exp_res.found,    o_found);
                check_field("position", exp_res.position, o_position);
                check_field("inserted", exp_res.inserted, o_inserted);
                check_field("full_res", exp_res.full_res, o_full_res);
                check_field("count",    exp_res.count,    o_count);
            end
        end
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_set_result typed_exp;
        t_stim_row   row;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = sset_pkg::CMD_INSERT;
        i_key         = '0;
        i_out_ready   = 1'b0;
        set_len       = 0;
        n_errors      = 0;
        idle_cycles   = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling
        for (int r = 0; r < DIRECTED_N; r++) begin
            row = directed_rows[r];
            typed_exp.found    = row.found;
            typed_exp.position = row.position;
            typed_exp.inserted = row.inserted;
            typed_exp.full_res = row.full_res;
            typed_exp.count    = row.count;
            drive_item(row.cmd, row.key, row.typed, typed_exp);
        end

        // random items under each idling pattern
        run_random_phase(RANDOM_PER_PHASE, 0, 0);
        run_random_phase(RANDOM_PER_PHASE, 78, 0);
        run_random_phase(RANDOM_PER_PHASE, 0, 78);
        run_random_phase(RANDOM_PER_PHASE, 33, 33);
        i_in_valid <= 1'b0;

        // drain, then allow for any stray late result
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
